// ===== src/point_transform_4x4_defines.svh =====
// ----------------------------------------------------------------------------
// point_transform_4x4_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef POINT_TRANSFORM_4X4_DEFINES_SVH
`define POINT_TRANSFORM_4X4_DEFINES_SVH

// Check a property on the rising clock edge, skipped while reset is low.
`define PT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, including during reset.
`define PT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pt4_pkg.sv =====
// ----------------------------------------------------------------------------
// pt4_pkg
// Shared constants and types for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package pt4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 64;
    // Dividend width: |acc| below 2^66, plus FRAC_BITS fraction bits.
    localparam int ACC_W     = 68;
    localparam int NUM_W     = 66 + FRAC_BITS;
    localparam int DEN_W     = 66;
    // Quotient bits that matter: integer part below 2^(32-FRAC_BITS) and FRAC_BITS.
    localparam int QINT_W    = WORD_W - FRAC_BITS;
    localparam int QBITS     = WORD_W + 1;
    localparam int DIV_STAGES = 11;
    localparam int BITS_PER_STAGE = 3;

    typedef enum logic {
        CMD_POINT     = 1'b0,
        CMD_DIRECTION = 1'b1
    } t_cmd;

    localparam logic [IDX_W-1:0] REG_R0C01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_R0C23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_R1C01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_R1C23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_R2C01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_R2C23 = 3'd5;
    localparam logic [IDX_W-1:0] REG_R3C01 = 3'd6;
    localparam logic [IDX_W-1:0] REG_R3C23 = 3'd7;

    localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Per-column state through the divider.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QBITS-1:0] quo;
        logic             neg;
        logic             big;
    } t_div_lane;

endpackage

// ===== src/pt4_div.sv =====
// ----------------------------------------------------------------------------
// pt4_div
// Pipelined restoring divider: three quotient bits per stage, stall aware.
// Computes |a| * 2^FRAC_BITS / |w| and flags an integer part out of range.
// ----------------------------------------------------------------------------
module pt4_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [pt4_pkg::NUM_W-1:0]     i_num,
    input  logic [pt4_pkg::DEN_W-1:0]     i_den,
    input  logic                          i_neg,
    output logic                          o_valid,
    output logic [pt4_pkg::QBITS-1:0]     o_quo,
    output logic                          o_neg,
    output logic                          o_big
);
    localparam int NS = pt4_pkg::DIV_STAGES;
    localparam int BP = pt4_pkg::BITS_PER_STAGE;
    localparam int NW = pt4_pkg::NUM_W;
    localparam int DW = pt4_pkg::DEN_W;
    localparam int QB = pt4_pkg::QBITS;
    // Shift for the first quotient bit (bit QB-1).
    localparam int TOP = QB - 1;

    pt4_pkg::t_div_lane r_lane [NS+1];
    logic [DW-1:0]      r_den  [NS+1];
    logic [NS:0]        r_vld;
    pt4_pkg::t_div_lane n_lane [NS];

    // Entry: load the dividend and divisor; the quotient starts empty.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lane[0].rem <= i_num;
            r_lane[0].quo <= '0;
            r_lane[0].neg <= i_neg;
            r_lane[0].big <= 1'b0;
            r_den[0]      <= i_den;
        end
    end

    // Each stage resolves BP quotient bits from the top down.
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_lane[s] = r_lane[s];
            for (int b = 0; b < BP; b++) begin
                logic [NW+QB-1:0] sh;
                int               k;
                k  = TOP - s * BP - b;
                sh = {{QB{1'b0}}, r_den[s]} << k;
                if (k >= 0 && {{QB{1'b0}}, n_lane[s].rem} >= sh) begin
                    n_lane[s].rem = n_lane[s].rem - sh[NW-1:0];
                    n_lane[s].quo[k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < NS; s++) begin
                r_lane[s+1] <= n_lane[s];
                r_den[s+1]  <= r_den[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NS-1:0], i_valid};
        end
    end

    assign o_valid = r_vld[NS];
    assign o_quo   = r_lane[NS].quo;
    assign o_neg   = r_lane[NS].neg;
    // A set top bit means the quotient reached 2^32: the true q0 is out of range.
    assign o_big   = r_lane[NS].big | (|r_lane[NS].quo[QB-1:pt4_pkg::WORD_W]);
endmodule

// ===== src/point_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// point_transform_4x4
// Homogeneous 4x4 vertex transform on signed Q16.16 vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (command, x, y, z) arrive on a valid/ready channel; result
//   words (x, y, z, w_zero, overflow) leave on another valid/ready channel.
//   The matrix sits in eight 64-bit registers written through a plain write
//   port (enable, index, data); write them only while the block is empty.
//   One result word per input word, in order.
// Throughput: one word per cycle, sustained while the receiver takes results.
// Pipeline: a word travels from the accepting edge to the edge raising o_valid
//   over 18 register stages: 32x32 products (loaded at the accepting edge),
//   column sums and rounding, sign and magnitude, dividend setup, a divider
//   input register plus eleven divider stages at three quotient bits each,
//   sign and saturation, and the output register.
// Stall: the whole pipe advances only when the output register is empty or
//   being taken, so a stalled receiver freezes every stage and nothing is lost.
// Reset: synchronous, active low; clears all valid bits and loads the
//   identity matrix.
// ----------------------------------------------------------------------------
module point_transform_4x4 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic        o_w_zero,
    output logic        o_overflow
);
    localparam int FB = pt4_pkg::FRAC_BITS;
    localparam int AW = pt4_pkg::ACC_W;
    localparam int NW = pt4_pkg::NUM_W;
    localparam int DW = pt4_pkg::DEN_W;
    localparam int QB = pt4_pkg::QBITS;
    localparam int NS = pt4_pkg::DIV_STAGES;

    logic [63:0] r_cfg [pt4_pkg::NUM_REGS];
    logic        adv;

    // Config register file with identity reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[pt4_pkg::REG_R0C01] <= 64'd65536;
            r_cfg[pt4_pkg::REG_R0C23] <= 64'd0;
            r_cfg[pt4_pkg::REG_R1C01] <= 64'd65536 << 32;
            r_cfg[pt4_pkg::REG_R1C23] <= 64'd0;
            r_cfg[pt4_pkg::REG_R2C01] <= 64'd0;
            r_cfg[pt4_pkg::REG_R2C23] <= 64'd65536;
            r_cfg[pt4_pkg::REG_R3C01] <= 64'd0;
            r_cfg[pt4_pkg::REG_R3C23] <= 64'd65536 << 32;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    function automatic logic signed [31:0] elem(input logic [63:0] w, input int c);
        return (c % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    // Global advance: whole pipe moves when output slot is free.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Stage 1: twelve products plus translation terms.
    logic               r1_vld;
    logic               r1_dir;
    logic signed [63:0] r1_p [4][3];
    logic signed [31:0] r1_t [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (adv) r1_vld <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_dir <= i_command;
            for (int c = 0; c < 4; c++) begin
                r1_p[c][0] <= i_in_x * elem(r_cfg[c/2], c);
                r1_p[c][1] <= i_in_y * elem(r_cfg[2 + c/2], c);
                r1_p[c][2] <= i_in_z * elem(r_cfg[4 + c/2], c);
                r1_t[c]    <= elem(r_cfg[6 + c/2], c);
            end
        end
    end

    // Stage 2: column sums, round half up, floor shift.
    logic               r2_vld;
    logic               r2_dir;
    logic signed [AW-1:0] r2_acc [4];
    logic signed [AW-1:0] n2_sum [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n2_sum[c] = AW'(r1_p[c][0]) + AW'(r1_p[c][1]) + AW'(r1_p[c][2])
                      + (r1_dir ? AW'(0) : (AW'(r1_t[c]) <<< FB))
                      + (AW'(1) <<< (FB - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (adv) r2_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_dir <= r1_dir;
            for (int c = 0; c < 4; c++) r2_acc[c] <= n2_sum[c] >>> FB;
        end
    end

    // Stage 3: magnitudes and signs; direction saturation decided here.
    logic             r3_vld;
    logic             r3_dir;
    logic             r3_wz;
    logic [DW-1:0]    r3_mag [3];
    logic             r3_neg [3];
    logic [DW-1:0]    r3_den;
    logic signed [31:0] r3_dres [3];
    logic             r3_dov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (adv) r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        logic ov;
        if (adv) begin
            ov = 1'b0;
            r3_dir <= r2_dir;
            r3_wz  <= (r2_acc[3] == '0);
            r3_den <= r2_acc[3][AW-1] ? DW'(-r2_acc[3]) : DW'(r2_acc[3]);
            for (int c = 0; c < 3; c++) begin
                r3_mag[c] <= r2_acc[c][AW-1] ? DW'(-r2_acc[c]) : DW'(r2_acc[c]);
                r3_neg[c] <= r2_acc[c][AW-1] ^ r2_acc[3][AW-1];
                if (r2_acc[c] > AW'(pt4_pkg::SAT_MAX)) begin
                    r3_dres[c] <= pt4_pkg::SAT_MAX; ov = 1'b1;
                end else if (r2_acc[c] < AW'(pt4_pkg::SAT_MIN)) begin
                    r3_dres[c] <= pt4_pkg::SAT_MIN; ov = 1'b1;
                end else begin
                    r3_dres[c] <= r2_acc[c][31:0];
                end
            end
            r3_dov <= ov;
        end
    end

    // Stage 4: dividend setup; zero W gets divisor one to stay harmless.
    logic           r4_vld;
    logic           r4_dir;
    logic           r4_wz;
    logic [NW-1:0]  r4_num [3];
    logic           r4_neg [3];
    logic [DW-1:0]  r4_den;
    logic signed [31:0] r4_dres [3];
    logic           r4_dov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else if (adv) r4_vld <= r3_vld;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_dir  <= r3_dir;
            r4_wz   <= r3_wz;
            r4_den  <= r3_wz ? DW'(1) : r3_den;
            r4_dres <= r3_dres;
            r4_dov  <= r3_dov;
            for (int c = 0; c < 3; c++) begin
                r4_num[c] <= NW'(r3_mag[c]) << FB;
                r4_neg[c] <= r3_neg[c];
            end
        end
    end

    // Divider lanes, one per column.
    logic [QB-1:0] d_quo [3];
    logic          d_neg [3];
    logic          d_big [3];
    logic          d_vld [3];

    for (genvar g = 0; g < 3; g++) begin : g_div
        pt4_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (r4_vld),
            .i_num   (r4_num[g]),
            .i_den   (r4_den),
            .i_neg   (r4_neg[g]),
            .o_valid (d_vld[g]),
            .o_quo   (d_quo[g]),
            .o_neg   (d_neg[g]),
            .o_big   (d_big[g])
        );
    end

    // Side band delayed along the divider: input register plus NS stages.
    logic           r_sb_dir  [NS+1];
    logic           r_sb_wz   [NS+1];
    logic signed [31:0] r_sb_dres [NS+1][3];
    logic           r_sb_dov  [NS+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb_dir[0]  <= r4_dir;
            r_sb_wz[0]   <= r4_wz;
            r_sb_dres[0] <= r4_dres;
            r_sb_dov[0]  <= r4_dov;
            for (int s = 1; s <= NS; s++) begin
                r_sb_dir[s]  <= r_sb_dir[s-1];
                r_sb_wz[s]   <= r_sb_wz[s-1];
                r_sb_dres[s] <= r_sb_dres[s-1];
                r_sb_dov[s]  <= r_sb_dov[s-1];
            end
        end
    end

    // Post-divider stage: sign, saturate, select mode.
    logic               r5_vld;
    logic signed [31:0] r5_res [3];
    logic               r5_wz;
    logic               r5_ov;
    logic signed [31:0] n5_res [3];
    logic               n5_ov;

    always_comb begin
        logic signed [QB:0] sq;
        n5_ov = 1'b0;
        for (int c = 0; c < 3; c++) begin
            sq = d_neg[c] ? -$signed({1'b0, d_quo[c]}) : $signed({1'b0, d_quo[c]});
            if (d_big[c]) begin
                n5_res[c] = d_neg[c] ? pt4_pkg::SAT_MIN : pt4_pkg::SAT_MAX;
                n5_ov = 1'b1;
            end else if (sq > (QB+1)'(pt4_pkg::SAT_MAX)) begin
                n5_res[c] = pt4_pkg::SAT_MAX; n5_ov = 1'b1;
            end else if (sq < (QB+1)'(pt4_pkg::SAT_MIN)) begin
                n5_res[c] = pt4_pkg::SAT_MIN; n5_ov = 1'b1;
            end else begin
                n5_res[c] = sq[31:0];
            end
        end
        if (r_sb_dir[NS]) begin
            n5_res = r_sb_dres[NS];
            n5_ov  = r_sb_dov[NS];
        end else if (r_sb_wz[NS]) begin
            for (int c = 0; c < 3; c++) n5_res[c] = '0;
            n5_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else if (adv) r5_vld <= d_vld[0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_res <= n5_res;
            r5_wz  <= !r_sb_dir[NS] && r_sb_wz[NS];
            r5_ov  <= n5_ov;
        end
    end

    // Output register.
    logic               r6_vld;
    logic signed [31:0] r6_res [3];
    logic               r6_wz;
    logic               r6_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else if (adv) r6_vld <= r5_vld;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_res <= r5_res;
            r6_wz  <= r5_wz;
            r6_ov  <= r5_ov;
        end
    end

    assign o_valid    = r6_vld;
    assign o_out_x    = r6_res[0];
    assign o_out_y    = r6_res[1];
    assign o_out_z    = r6_res[2];
    assign o_w_zero   = r6_wz;
    assign o_overflow = r6_ov;
endmodule

// ===== src/pt4_checker.sv =====
// ----------------------------------------------------------------------------
// pt4_checker
// Port-level checks for the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_transform_4x4_defines.svh"

module pt4_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_out_x,
    input logic [31:0] o_out_y,
    input logic [31:0] o_out_z,
    input logic        o_w_zero,
    input logic        o_overflow
);
    // Zero W forces zero outputs and no overflow.
    `PT_ASSERT(a_wz_zero, i_clk, i_rst_n, (o_valid && o_w_zero) |-> (o_out_x == 0 && o_out_y == 0 && o_out_z == 0 && !o_overflow), "w_zero with nonzero result")
    // Held word stays put while stalled.
    `PT_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_out_x) && $stable(o_w_zero)), "output changed under stall")
    // Input side is ready whenever output is free.
    `PT_ASSERT(a_ready, i_clk, i_rst_n, (!o_valid || i_ready) |-> o_ready, "input stalled with free output")
    // A waiting input word is held until taken.
    `PT_ASSERT(a_in_hold, i_clk, i_rst_n, (i_valid && !o_ready) |=> i_valid, "input word dropped while waiting")
    // Reset clears output valid.
    `PT_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

bind point_transform_4x4 pt4_checker u_pt4_checker (.*);

// ===== tb/tb_point_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// tb_point_transform_4x4
// Drives vectors through the 4x4 transform under several matrices and checks
// every result word against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_point_transform_4x4;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               wz, ov;
    } t_vertex_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic signed [31:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic        o_w_zero, o_overflow;

    logic [63:0]  matrix_regs [pt4_pkg::NUM_REGS];
    t_vertex_out  pending_vertices[$];
    int           mismatch_count = 0;
    int           result_count = 0;
    int           word_count = 0;
    int           wzero_seen = 0;
    int           ovf_seen = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    point_transform_4x4 dut (.*);

    always #10 i_clk = ~i_clk;

    // Matrix element m[r][c], signed Q16.16
    function automatic longint mat_elem(int r, int c);
        logic [63:0] w;
        w = matrix_regs[r * 2 + c / 2];
        return (c % 2) ? longint'(signed'(w[63:32])) : longint'(signed'(w[31:0]));
    endfunction

    // Column sum rounded half up to FRAC_BITS
    function automatic logic signed [95:0] column_sum(logic signed [31:0] v[3], int c,
                                                     bit point);
        logic signed [95:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += 96'(signed'(v[i])) * 96'(mat_elem(i, c));
        if (point)
            acc += 96'(mat_elem(3, c)) <<< pt4_pkg::FRAC_BITS;
        acc += 96'sd1 <<< (pt4_pkg::FRAC_BITS - 1);
        return acc >>> pt4_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] saturate(logic signed [127:0] a, ref logic ov);
        if (a > 128'sh7FFF_FFFF) begin
            ov = 1'b1;
            return pt4_pkg::SAT_MAX;
        end
        if (a < -128'sh8000_0000) begin
            ov = 1'b1;
            return pt4_pkg::SAT_MIN;
        end
        return a[31:0];
    endfunction

    // Truncating divide; SV signed division already rounds toward zero
    function automatic logic signed [31:0] persp_divide(logic signed [95:0] a,
                                                         logic signed [95:0] w,
                                                         ref logic ov);
        logic signed [127:0] q;
        q = (128'(a) <<< pt4_pkg::FRAC_BITS) / 128'(w);
        return saturate(q, ov);
    endfunction

    function automatic t_vertex_out transform_vertex(pt4_pkg::t_cmd cmd,
                                                     logic signed [31:0] x,
                                                     logic signed [31:0] y,
                                                     logic signed [31:0] z);
        t_vertex_out r;
        logic signed [31:0] v[3];
        logic signed [95:0] acc[3], w;
        logic ov;
        bit point;
        v[0] = x; v[1] = y; v[2] = z;
        point = (cmd == pt4_pkg::CMD_POINT);
        ov = 1'b0;
        r.x = 0; r.y = 0; r.z = 0; r.wz = 1'b0;
        for (int c = 0; c < 3; c++)
            acc[c] = column_sum(v, c, point);
        if (!point) begin
            r.x = saturate(128'(acc[0]), ov);
            r.y = saturate(128'(acc[1]), ov);
            r.z = saturate(128'(acc[2]), ov);
        end else begin
            w = column_sum(v, 3, 1'b1);
            if (w == 0) begin
                r.wz = 1'b1;
            end else begin
                r.x = persp_divide(acc[0], w, ov);
                r.y = persp_divide(acc[1], w, ov);
                r.z = persp_divide(acc[2], w, ov);
            end
        end
        r.ov = ov;
        return r;
    endfunction

    // Send one word and queue its prediction on accept; valid stays high
    // so the next word can follow back to back
    task automatic send_vertex(pt4_pkg::t_cmd cmd, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_in_x <= x; i_in_y <= y; i_in_z <= z;
        do @(posedge i_clk); while (!o_ready);
        pending_vertices.push_back(transform_vertex(cmd, x, y, z));
        word_count++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every expected result
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    task automatic write_matrix_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        matrix_regs[idx] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(4) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'($signed($urandom_range(0, 1024)) - 512);
            default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        endcase
    endfunction

    task automatic load_identity();
        write_matrix_reg(pt4_pkg::REG_R0C01, 64'd65536);
        write_matrix_reg(pt4_pkg::REG_R0C23, 64'd0);
        write_matrix_reg(pt4_pkg::REG_R1C01, 64'd65536 << 32);
        write_matrix_reg(pt4_pkg::REG_R1C23, 64'd0);
        write_matrix_reg(pt4_pkg::REG_R2C01, 64'd0);
        write_matrix_reg(pt4_pkg::REG_R2C23, 64'd65536);
        write_matrix_reg(pt4_pkg::REG_R3C01, 64'd0);
        write_matrix_reg(pt4_pkg::REG_R3C23, 64'd65536 << 32);
    endtask

    task automatic test_directed();
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000,
                      32'hFFFF_0000, 32'h1};
        // Extremes on identity, both commands
        for (int i = 0; i < 6; i++) begin
            send_vertex(pt4_pkg::CMD_POINT, edge_vals[i], edge_vals[(i + 1) % 6],
                        edge_vals[(i + 2) % 6]);
            send_vertex(pt4_pkg::CMD_DIRECTION, edge_vals[i], edge_vals[(i + 3) % 6],
                        edge_vals[(i + 5) % 6]);
        end
        wait_drained();
        // Zero W: column 3 all zero
        write_matrix_reg(pt4_pkg::REG_R3C23, 64'd0);
        send_vertex(pt4_pkg::CMD_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_vertex(pt4_pkg::CMD_DIRECTION, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        wait_drained();
        // Tiny W forces divide overflow, negative W flips signs
        write_matrix_reg(pt4_pkg::REG_R3C23, 64'h0000_0001_0000_0000);
        send_vertex(pt4_pkg::CMD_POINT, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        wait_drained();
        write_matrix_reg(pt4_pkg::REG_R3C23, 64'hFFFF_0000_0000_0000);
        send_vertex(pt4_pkg::CMD_POINT, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000);
        // Max elements: direction sums saturate
        wait_drained();
        for (int i = 0; i < 8; i++)
            write_matrix_reg(3'(i), 64'h7FFF_FFFF_7FFF_FFFF);
        send_vertex(pt4_pkg::CMD_DIRECTION, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(pt4_pkg::CMD_DIRECTION, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_vertex(pt4_pkg::CMD_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        wait_drained();
        for (int i = 0; i < 8; i++)
            write_matrix_reg(3'(i), 64'h8000_0000_8000_0000);
        send_vertex(pt4_pkg::CMD_DIRECTION, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(pt4_pkg::CMD_POINT, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
        wait_drained();
    endtask

    task automatic test_random_phase(int n_items, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        // New matrix: mostly modest values, occasionally random bits
        for (int i = 0; i < 8; i++)
            write_matrix_reg(3'(i), ($urandom_range(3) == 0) ? {$urandom(), $urandom()}
                                                              : {rand_q(), rand_q()});
        for (int k = 0; k < n_items; k++) begin
            send_vertex(pt4_pkg::t_cmd'($urandom_range(1)), rand_q(), rand_q(), rand_q());
            // Hold off until everything has drained
            if (k == n_items / 2) begin
                i_valid <= 1'b0;
                while (pending_vertices.size() != 0)
                    @(negedge i_clk);
            end
        end
        wait_drained();
    endtask

    // Randomize receiver ready
    always @(negedge i_clk) begin
        i_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_vertex_out exp_v;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            wzero_seen += o_w_zero;
            ovf_seen += o_overflow;
            if (pending_vertices.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result word x=%h", o_out_x);
            end else begin
                exp_v = pending_vertices.pop_front();
                if (o_out_x !== exp_v.x || o_out_y !== exp_v.y || o_out_z !== exp_v.z ||
                    o_w_zero !== exp_v.wz || o_overflow !== exp_v.ov) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: exp %h %h %h wz=%b ov=%b got %h %h %h wz=%b ov=%b",
                                 exp_v.x, exp_v.y, exp_v.z, exp_v.wz, exp_v.ov,
                                 o_out_x, o_out_y, o_out_z, o_w_zero, o_overflow);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        matrix_regs = '{64'd65536, 64'd0, 64'd65536 << 32, 64'd0,
                        64'd0, 64'd65536, 64'd0, 64'd65536 << 32};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phase(120, 9, 56);
        test_random_phase(120, 56, 9);
        test_random_phase(120, 0, 0);
        test_random_phase(120, 9, 56);
        test_random_phase(120, 0, 0);
        load_identity();
        test_random_phase(100, 20, 20);
        if (pending_vertices.size() != 0)
            mismatch_count++;
        $display("Sent %0d vertices, checked %0d results (%0d zero-W, %0d overflow).",
                 word_count, result_count, wzero_seen, ovf_seen);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== point_transform_4x4.f =====
+incdir+src
src/pt4_pkg.sv
src/pt4_div.sv
src/point_transform_4x4.sv
src/pt4_checker.sv
tb/tb_point_transform_4x4.sv
